// ----- design/composition_rejection_sampler_defines.svh -----
// ----------------------------------------------------------------------------
// Composition-rejection sampler assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPOSITION_REJECTION_SAMPLER_DEFINES_SVH
`define COMPOSITION_REJECTION_SAMPLER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define CRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// Composition-rejection sampler package
// Register map, command and status codes, configuration record.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 3'd5;

    localparam logic CMD_ALTER  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALTERED  = 2'd3;

    typedef struct packed {
        logic             bin_mode;
        logic [VAL_W-1:0] low_bound;
        logic [VAL_W-1:0] high_bound;
        logic [5:0]       num_groups;
        logic [VAL_W-1:0] inv_bin_size;
        logic [VAL_W-1:0] bin_width;
    } t_cfg;

endpackage

// ----- design/crs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module crs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/crs_classify.sv -----
// ----------------------------------------------------------------------------
// Group classifier
// Group of a propensity, and upper bound of a group.
// ----------------------------------------------------------------------------
module crs_classify import crs_pkg::*; #(
    parameter int MAX_GROUPS = 32
) (
    input  t_cfg                               i_cfg,
    input  logic [VAL_W-1:0]                   i_value,
    input  logic [2*VAL_W-1:0]                 i_prod,   // (v - lo) * inv, registered
    input  logic [$clog2(MAX_GROUPS+1)-1:0]    i_group,
    output logic [$clog2(MAX_GROUPS+1)-1:0]    o_group,
    output logic [$clog2(MAX_GROUPS+1)-1:0]    o_last,
    output logic [VAL_W-1:0]                   o_bound
);
    localparam int GW = $clog2(MAX_GROUPS+1);

    logic [6:0]        ng;
    logic [GW-1:0]     last;
    logic [VAL_W-1:0]  lin_g;
    logic [GW-1:0]     half_g;
    logic [63:0]       need;
    logic [39:0]       lin_b;
    logic [6:0]        gp1;

    always_comb begin
        ng = {1'b0, i_cfg.num_groups};
        if (ng < 7'd1) begin
            ng = 7'd1;
        end else if (ng > 7'(MAX_GROUPS)) begin
            ng = 7'(MAX_GROUPS);
        end
        last = GW'(ng - 7'd1);
    end

    // halving bins: first k below the last group whose ceiling threshold is met
    always_comb begin
        half_g = last;
        need   = '0;
        for (int k = MAX_GROUPS - 2; k >= 0; k--) begin
            need = (64'(i_cfg.high_bound) + ((64'd1 << (k + 1)) - 64'd1)) >> (k + 1);
            if ((7'(k + 1) < ng) && (64'(i_value) >= need)) begin
                half_g = GW'(k);
            end
        end
    end

    always_comb begin
        lin_g = i_prod[2*VAL_W-1:VAL_W];
        if (i_value == '0) begin
            o_group = GW'(MAX_GROUPS);
        end else if (i_cfg.bin_mode) begin
            if (i_value <= i_cfg.low_bound) begin
                o_group = '0;
            end else if (lin_g > VAL_W'(last)) begin
                o_group = last;
            end else begin
                o_group = GW'(lin_g);
            end
        end else begin
            o_group = half_g;
        end
    end

    always_comb begin
        gp1   = 7'(i_group) + 7'd1;
        lin_b = 40'(i_cfg.low_bound) + 40'(gp1) * 40'(i_cfg.bin_width);
        if (i_cfg.bin_mode) begin
            if (gp1 >= ng) begin
                o_bound = i_cfg.high_bound;
            end else if (lin_b > 40'hFFFF_FFFF) begin
                o_bound = '1;
            end else begin
                o_bound = lin_b[VAL_W-1:0];
            end
        end else begin
            o_bound = i_cfg.high_bound >> i_group;
        end
    end

    assign o_last = last;
endmodule

// ----- design/composition_rejection_sampler.sv -----
// ----------------------------------------------------------------------------
// Composition-rejection sampler
// Grouped propensity store with alter and single-attempt sampling commands.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  command   in         start & !busy             i_cmd, i_element_index,
//                                                 i_new_value, i_rand_*
//  result    out        o_strobe (one cycle)      o_chosen_index, o_chosen_group,
//                                                 o_status
//  config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
//  After reset a clearing pass over every element and group entry builds
//  the zero group; busy stays high, config writes are still taken.
//  Alter: states A0 to A4 carry the read-modify-write chain through the
//  member, list and group RAMs; an unchanged group ends at A2.
//  Sample: states S0 and S1, the walk W, then S2 to S5; the group-sum RAM is
//  walked one entry a cycle. Early outs (empty) end at S0 or S2.
//  The receiver cannot stall; one command is in flight at a time.
// ----------------------------------------------------------------------------
module composition_rejection_sampler import crs_pkg::*; #(
    parameter int NUM_ELEMENTS = 1024,
    parameter int MAX_GROUPS   = 32,
    parameter int RAND_BITS    = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [$clog2(NUM_ELEMENTS)-1:0]   i_element_index,
    input  logic [VAL_W-1:0]                  i_new_value,
    input  logic [RAND_BITS-1:0]              i_rand_group,
    input  logic [RAND_BITS-1:0]              i_rand_slot,
    input  logic [RAND_BITS-1:0]              i_rand_accept,
    output logic                              o_strobe,
    output logic [$clog2(NUM_ELEMENTS)-1:0]   o_chosen_index,
    output logic [$clog2(MAX_GROUPS+1)-1:0]   o_chosen_group,
    output logic [STATUS_W-1:0]               o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data
);
    localparam int IW      = $clog2(NUM_ELEMENTS);
    localparam int GW      = $clog2(MAX_GROUPS+1);
    localparam int CW      = $clog2(NUM_ELEMENTS+1);
    localparam int TW      = VAL_W + CW;
    localparam int LD      = (MAX_GROUPS + 1) * NUM_ELEMENTS;
    localparam int LAW     = $clog2(LD);
    localparam int CLR_LEN = (NUM_ELEMENTS > MAX_GROUPS + 1) ? NUM_ELEMENTS : MAX_GROUPS + 1;
    localparam int CLRW    = $clog2(CLR_LEN);
    localparam logic [GW-1:0] ZG = GW'(MAX_GROUPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_A0   = 4'd1;
    localparam logic [3:0] S_A1   = 4'd2;
    localparam logic [3:0] S_A2   = 4'd3;
    localparam logic [3:0] S_A3   = 4'd4;
    localparam logic [3:0] S_A4   = 4'd5;
    localparam logic [3:0] S_S0   = 4'd6;
    localparam logic [3:0] S_S1   = 4'd7;
    localparam logic [3:0] S_W    = 4'd8;
    localparam logic [3:0] S_S2   = 4'd9;
    localparam logic [3:0] S_S3   = 4'd10;
    localparam logic [3:0] S_S4   = 4'd11;
    localparam logic [3:0] S_S5   = 4'd12;

    t_cfg              r_cfg;
    logic [3:0]        r_state, n_state;
    logic              r_clearing;
    logic [CLRW-1:0]   r_clr;

    logic [IW-1:0]     r_n;
    logic [VAL_W-1:0]  r_pnew;
    logic [RAND_BITS-1:0] r_rg, r_rs, r_ra;
    logic [2*VAL_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_pold;
    logic [GW-1:0]     r_og, r_ng, r_g;
    logic [IW-1:0]     r_pos, r_slot, r_pick;
    logic [TW-1:0]     r_gt, r_part, r_thr;
    logic [CW-1:0]     r_cnt;
    logic [VAL_W-1:0]  r_bound, r_athr;

    logic              r_strobe;
    logic [IW-1:0]     r_o_index;
    logic [GW-1:0]     r_o_group;
    logic [STATUS_W-1:0] r_o_status;

    // RAM ports
    logic              prop_we;
    logic [IW-1:0]     prop_waddr, prop_raddr;
    logic [VAL_W-1:0]  prop_wdata, prop_rdata;
    logic              memb_we;
    logic [IW-1:0]     memb_waddr, memb_raddr;
    logic [GW+IW-1:0]  memb_wdata, memb_rdata;
    logic              list_we;
    logic [LAW-1:0]    list_waddr, list_raddr;
    logic [IW-1:0]     list_wdata, list_rdata;
    logic              grp_we;
    logic [GW-1:0]     grp_waddr, grp_raddr;
    logic [CW+TW-1:0]  grp_wdata, grp_rdata;

    logic [GW-1:0]     cls_group, cls_last;
    logic [VAL_W-1:0]  cls_bound;
    logic [CW-1:0]     grp_cnt;
    logic [TW-1:0]     grp_tot, walk_sum;
    logic              in_range;
    logic              walk_stop;

    function automatic logic [LAW-1:0] list_addr(input logic [GW-1:0] g,
                                                 input logic [IW-1:0] s);
        return LAW'(g) * LAW'(NUM_ELEMENTS) + LAW'(s);
    endfunction

    crs_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ELEMENTS)) u_prop (
        .i_clk(i_clk), .i_we(prop_we), .i_waddr(prop_waddr), .i_wdata(prop_wdata),
        .i_raddr(prop_raddr), .o_rdata(prop_rdata)
    );
    crs_ram #(.WIDTH(GW+IW), .DEPTH(NUM_ELEMENTS)) u_memb (
        .i_clk(i_clk), .i_we(memb_we), .i_waddr(memb_waddr), .i_wdata(memb_wdata),
        .i_raddr(memb_raddr), .o_rdata(memb_rdata)
    );
    crs_ram #(.WIDTH(IW), .DEPTH(LD)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr), .i_wdata(list_wdata),
        .i_raddr(list_raddr), .o_rdata(list_rdata)
    );
    crs_ram #(.WIDTH(CW+TW), .DEPTH(MAX_GROUPS+1)) u_grp (
        .i_clk(i_clk), .i_we(grp_we), .i_waddr(grp_waddr), .i_wdata(grp_wdata),
        .i_raddr(grp_raddr), .o_rdata(grp_rdata)
    );

    crs_classify #(.MAX_GROUPS(MAX_GROUPS)) u_cls (
        .i_cfg(r_cfg), .i_value(r_pnew), .i_prod(r_prod), .i_group(r_g),
        .o_group(cls_group), .o_last(cls_last), .o_bound(cls_bound)
    );

    assign grp_cnt   = grp_rdata[CW+TW-1:TW];
    assign grp_tot   = grp_rdata[TW-1:0];
    assign walk_sum  = r_part + grp_tot;
    assign walk_stop = (walk_sum > r_thr) || (r_g == cls_last);
    assign in_range  = ({1'b0, r_n} < (IW+1)'(NUM_ELEMENTS));

    assign busy           = r_clearing || (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_strobe;
    assign o_chosen_index = r_o_index;
    assign o_chosen_group = r_o_group;
    assign o_status       = r_o_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_mode     <= 1'b1;
            r_cfg.low_bound    <= '0;
            r_cfg.high_bound   <= VAL_W'(65536);
            r_cfg.num_groups   <= 6'd1;
            r_cfg.inv_bin_size <= VAL_W'(65536);
            r_cfg.bin_width    <= VAL_W'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BIN_MODE:   r_cfg.bin_mode     <= i_cfg_data[0];
                CFG_LOW_BOUND:  r_cfg.low_bound    <= i_cfg_data;
                CFG_HIGH_BOUND: r_cfg.high_bound   <= i_cfg_data;
                CFG_NUM_GROUPS: r_cfg.num_groups   <= i_cfg_data[5:0];
                CFG_INV_BIN:    r_cfg.inv_bin_size <= i_cfg_data;
                CFG_BIN_WIDTH:  r_cfg.bin_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start && !busy) n_state = (i_cmd == CMD_ALTER) ? S_A0 : S_S0;
            S_A0:   n_state = in_range ? S_A1 : S_IDLE;
            S_A1:   n_state = S_A2;
            S_A2:   n_state = (r_og == r_ng) ? S_IDLE : S_A3;
            S_A3:   n_state = S_A4;
            S_A4:   n_state = S_IDLE;
            S_S0:   n_state = (r_gt == '0) ? S_IDLE : S_S1;
            S_S1:   n_state = S_W;
            S_W:    if (walk_stop) n_state = S_S2;
            S_S2:   n_state = (r_cnt == '0) ? S_IDLE : S_S3;
            S_S3:   n_state = S_S4;
            S_S4:   n_state = S_S5;
            S_S5:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port steering; the clearing pass owns the write ports
    always_comb begin
        prop_we = 1'b0;  prop_waddr = r_n;  prop_wdata = r_pnew;  prop_raddr = r_n;
        memb_we = 1'b0;  memb_waddr = r_n;  memb_wdata = {r_ng, r_pos};  memb_raddr = r_n;
        list_we = 1'b0;  list_waddr = list_addr(r_og, r_pos);  list_wdata = list_rdata;
        list_raddr = list_addr(r_g, r_slot);
        grp_we = 1'b0;   grp_waddr = r_ng;  grp_wdata = '0;  grp_raddr = r_g;
        if (r_clearing) begin
            prop_we    = ({1'b0, r_clr} < (CLRW+1)'(NUM_ELEMENTS));
            prop_waddr = r_clr[IW-1:0];
            prop_wdata = '0;
            memb_we    = prop_we;
            memb_waddr = r_clr[IW-1:0];
            memb_wdata = {ZG, r_clr[IW-1:0]};
            list_we    = prop_we;
            list_waddr = list_addr(ZG, r_clr[IW-1:0]);
            list_wdata = r_clr[IW-1:0];
            grp_we     = ({1'b0, r_clr} < (CLRW+1)'(MAX_GROUPS + 1));
            grp_waddr  = r_clr[GW-1:0];
            grp_wdata  = (r_clr[GW-1:0] == ZG) ? {CW'(NUM_ELEMENTS), TW'(0)} : '0;
        end else begin
            unique case (r_state)
                S_A1: begin
                    prop_we   = 1'b1;
                    grp_raddr = memb_rdata[GW+IW-1:IW];
                end
                S_A2: begin
                    grp_we = 1'b1;
                    if (r_og == r_ng) begin
                        grp_waddr = r_ng;
                        grp_wdata = {grp_cnt, grp_tot - TW'(r_pold) + TW'(r_pnew)};
                    end else begin
                        grp_waddr  = r_og;
                        grp_wdata  = {grp_cnt - CW'(1), grp_tot - TW'(r_pold)};
                        list_raddr = list_addr(r_og, IW'(grp_cnt - CW'(1)));
                    end
                end
                S_A3: begin
                    // last member of the old group fills the hole
                    list_we    = 1'b1;
                    memb_we    = 1'b1;
                    memb_waddr = list_rdata;
                    memb_wdata = {r_og, r_pos};
                    grp_raddr  = r_ng;
                end
                S_A4: begin
                    grp_we     = 1'b1;
                    grp_waddr  = r_ng;
                    grp_wdata  = {grp_cnt + CW'(1), grp_tot + TW'(r_pnew)};
                    memb_we    = 1'b1;
                    memb_wdata = {r_ng, IW'(grp_cnt)};
                    list_we    = 1'b1;
                    list_waddr = list_addr(r_ng, IW'(grp_cnt));
                    list_wdata = r_n;
                end
                S_S1:    grp_raddr = '0;
                S_W:     grp_raddr = r_g + GW'(1);
                S_S4:    prop_raddr = list_rdata;
                default: ;
            endcase
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_gt       <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (r_clearing) begin
                if (r_clr == CLRW'(CLR_LEN - 1)) r_clearing <= 1'b0;
                r_clr <= r_clr + CLRW'(1);
            end
            if (r_state == S_A1) r_gt <= r_gt - TW'(prop_rdata) + TW'(r_pnew);
            unique case (r_state)
                S_A0:    if (!in_range) r_strobe <= 1'b1;
                S_A2:    if (r_og == r_ng) r_strobe <= 1'b1;
                S_A4:    r_strobe <= 1'b1;
                S_S0:    if (r_gt == '0) r_strobe <= 1'b1;
                S_S2:    if (r_cnt == '0) r_strobe <= 1'b1;
                S_S5:    r_strobe <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n    <= i_element_index;
                r_pnew <= i_new_value;
                r_rg   <= i_rand_group;
                r_rs   <= i_rand_slot;
                r_ra   <= i_rand_accept;
            end
            S_A0: begin
                r_prod     <= 64'(r_pnew - r_cfg.low_bound) * 64'(r_cfg.inv_bin_size);
                r_o_index  <= r_n;
                r_o_group  <= '0;
                r_o_status <= ST_ALTERED;
            end
            S_A1: begin
                r_pold <= prop_rdata;
                r_og   <= memb_rdata[GW+IW-1:IW];
                r_pos  <= memb_rdata[IW-1:0];
                r_ng   <= cls_group;
            end
            S_A2, S_A4: r_o_group <= r_ng;
            S_S0: begin
                r_thr      <= TW'(((TW+RAND_BITS)'(r_gt) * (TW+RAND_BITS)'(r_rg)) >> RAND_BITS);
                r_o_index  <= '0;
                r_o_group  <= '0;
                r_o_status <= ST_EMPTY;
            end
            S_S1: begin
                r_g    <= '0;
                r_part <= '0;
            end
            S_W: begin
                if (walk_stop) begin
                    r_cnt <= grp_cnt;
                end else begin
                    r_part <= walk_sum;
                    r_g    <= r_g + GW'(1);
                end
            end
            S_S2: begin
                r_slot    <= IW'(((CW+RAND_BITS)'(r_cnt) * (CW+RAND_BITS)'(r_rs)) >> RAND_BITS);
                r_bound   <= cls_bound;
                r_o_group <= r_g;
            end
            S_S3: r_athr <= VAL_W'(((VAL_W+RAND_BITS)'(r_bound) * (VAL_W+RAND_BITS)'(r_ra))
                                   >> RAND_BITS);
            S_S4: r_pick <= list_rdata;
            S_S5: begin
                r_o_index  <= r_pick;
                r_o_status <= (prop_rdata > r_athr) ? ST_ACCEPTED : ST_REJECTED;
            end
            default: ;
        endcase
    end
endmodule

// ----- design/crs_checker.sv -----
// ----------------------------------------------------------------------------
// Composition-rejection sampler port checker
// Command/result ordering seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "composition_rejection_sampler_defines.svh"

module crs_checker import crs_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input logic [9:0]          o_chosen_index,
    input logic [STATUS_W-1:0] o_status
);
    // a transfer always sets the block busy
    `CRS_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy low after transfer")
    // results only follow work in flight
    `CRS_ASSERT_NOW(a_strobe_has_cmd, o_strobe, $past(busy), "result without a command")
    // result strobe never repeats back to back
    `CRS_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe, "result repeated")
    // empty attempts carry index zero
    `CRS_ASSERT_NOW(a_empty_index, o_strobe && (o_status == ST_EMPTY), o_chosen_index == '0,
                    "empty result with nonzero index")
endmodule

bind composition_rejection_sampler crs_checker u_crs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_strobe(o_strobe),
    .o_chosen_index(o_chosen_index), .o_status(o_status)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Composition-rejection sampler testbench
// Drives alter and sampling commands, keeps a predictor of the grouped
// propensity store and checks each result strobe field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import crs_pkg::*;

    localparam int N_ELEM  = 1024;
    localparam int N_GRP   = 32;
    localparam int ZERO_G  = N_GRP;
    localparam int R_BITS  = 24;

    typedef struct {
        logic [9:0]          idx;
        logic [5:0]          grp;
        logic [STATUS_W-1:0] st;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cmd;
    logic [9:0]          i_element_index;
    logic [VAL_W-1:0]    i_new_value;
    logic [R_BITS-1:0]   i_rand_group, i_rand_slot, i_rand_accept;
    logic                o_strobe;
    logic [9:0]          o_chosen_index;
    logic [5:0]          o_chosen_group;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    composition_rejection_sampler dut (.*);

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor
    // Shadow copy of the register set
    logic        p_mode;
    logic [31:0] p_lo, p_hi, p_inv, p_bw;
    logic [5:0]  p_ngrp;

    // Shadow copy of the grouped store
    logic [31:0] prop_mem [N_ELEM];
    int          grp_of_elem [N_ELEM];
    int          slot_of_elem [N_ELEM];
    logic [9:0]  grp_list [N_GRP+1][N_ELEM];
    int          grp_cnt [N_GRP+1];
    logic [63:0] grp_sum [N_GRP+1];
    logic [63:0] total_sum;

    t_outcome outcome_q[$];
    int       err_cnt  = 0;
    int       idle_pct = 0;

    function automatic int groups_in_use();
        if (p_ngrp < 1) return 1;
        if (p_ngrp > N_GRP) return N_GRP;
        return int'(p_ngrp);
    endfunction

    function automatic int file_group(logic [31:0] v);
        int          ng;
        logic [63:0] g, need;
        ng = groups_in_use();
        if (v == 0) return ZERO_G;
        if (p_mode) begin
            if (v <= p_lo) return 0;
            g = (64'(v - p_lo) * 64'(p_inv)) >> 32;
            return (g > 64'(ng - 1)) ? ng - 1 : int'(g);
        end
        for (int k = 0; k + 1 < ng; k++) begin
            need = (64'(p_hi) + ((64'd1 << (k + 1)) - 1)) >> (k + 1);
            if (64'(v) >= need) return k;
        end
        return ng - 1;
    endfunction

    function automatic logic [63:0] upper_bound(int g);
        logic [63:0] b;
        if (p_mode) begin
            if (g + 1 >= groups_in_use()) b = 64'(p_hi);
            else b = 64'(p_lo) + 64'(g + 1) * 64'(p_bw);
        end else begin
            b = 64'(p_hi) >> g;
        end
        return (b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : b;
    endfunction

    task automatic clear_store();
        p_mode = 1'b1; p_lo = 0; p_hi = 32'h10000; p_ngrp = 1;
        p_inv = 32'h10000; p_bw = 32'h10000;
        for (int g = 0; g <= N_GRP; g++) begin
            grp_cnt[g] = 0;
            grp_sum[g] = 0;
        end
        for (int i = 0; i < N_ELEM; i++) begin
            prop_mem[i]         = 0;
            grp_of_elem[i]      = ZERO_G;
            slot_of_elem[i]     = i;
            grp_list[ZERO_G][i] = 10'(i);
        end
        grp_cnt[ZERO_G] = N_ELEM;
        total_sum = 0;
    endtask

    function automatic t_outcome predict_alter(int n, logic [31:0] v);
        t_outcome r;
        logic [31:0] old_v;
        int ng, og, pos;
        logic [9:0] last;
        old_v = prop_mem[n];
        ng = file_group(v);
        og = grp_of_elem[n];
        total_sum = total_sum - old_v + v;
        prop_mem[n] = v;
        if (og == ng) begin
            grp_sum[ng] = grp_sum[ng] - old_v + v;
        end else begin
            // swap-with-last out of the old list
            pos  = slot_of_elem[n];
            last = grp_list[og][grp_cnt[og] - 1];
            grp_list[og][pos] = last;
            slot_of_elem[last] = pos;
            grp_cnt[og]--;
            grp_sum[og] -= old_v;
            grp_of_elem[n]  = ng;
            slot_of_elem[n] = grp_cnt[ng];
            grp_list[ng][grp_cnt[ng]] = 10'(n);
            grp_cnt[ng]++;
            grp_sum[ng] += v;
        end
        r.idx = 10'(n); r.grp = 6'(ng); r.st = ST_ALTERED;
        return r;
    endfunction

    function automatic t_outcome predict_attempt(logic [23:0] rg, logic [23:0] rs,
                                                 logic [23:0] ra);
        t_outcome r;
        logic [95:0] thresh, run;
        logic [63:0] slot, bnd;
        int ng, g;
        logic [9:0] pick;
        ng = groups_in_use();
        if (total_sum == 0) begin
            r.idx = 0; r.grp = 0; r.st = ST_EMPTY;
            return r;
        end
        thresh = (96'(total_sum) * 96'(rg)) >> R_BITS;
        run = 0;
        for (g = 0; g < ng; g++) begin
            run += 96'(grp_sum[g]);
            if (run > thresh) break;
        end
        if (g >= ng) g = ng - 1;     // walk ran off the end
        if (grp_cnt[g] == 0) begin
            r.idx = 0; r.grp = 6'(g); r.st = ST_EMPTY;
            return r;
        end
        slot = (64'(grp_cnt[g]) * 64'(rs)) >> R_BITS;
        pick = grp_list[g][slot];
        bnd  = upper_bound(g);
        r.idx = pick; r.grp = 6'(g);
        r.st  = (64'(prop_mem[pick]) > ((bnd * 64'(ra)) >> R_BITS)) ? ST_ACCEPTED
                                                                    : ST_REJECTED;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers
    // Register write; valid is left high so back-to-back writes need no toggle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BIN_MODE:   p_mode = data[0];
            CFG_LOW_BOUND:  p_lo   = data;
            CFG_HIGH_BOUND: p_hi   = data;
            CFG_NUM_GROUPS: p_ngrp = data[5:0];
            CFG_INV_BIN:    p_inv  = data;
            CFG_BIN_WIDTH:  p_bw   = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic mode, logic [31:0] lo, logic [31:0] hi, logic [5:0] ng,
                            logic [31:0] inv, logic [31:0] bw);
        write_reg(CFG_BIN_MODE, 32'(mode));
        write_reg(CFG_LOW_BOUND, lo);
        write_reg(CFG_HIGH_BOUND, hi);
        write_reg(CFG_NUM_GROUPS, 32'(ng));
        write_reg(CFG_INV_BIN, inv);
        write_reg(CFG_BIN_WIDTH, bw);
        i_cfg_valid <= 1'b0;
    endtask

    // One command transfer; start stays high on return
    task automatic send_cmd(logic cmd, logic [9:0] idx, logic [31:0] v,
                            logic [23:0] rg, logic [23:0] rs, logic [23:0] ra);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_element_index <= idx;
        i_new_value     <= v;
        i_rand_group    <= rg;
        i_rand_slot     <= rs;
        i_rand_accept   <= ra;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cmd == CMD_ALTER) outcome_q.push_back(predict_alter(int'(idx), v));
        else outcome_q.push_back(predict_attempt(rg, rs, ra));
    endtask

    task automatic alter_elem(int idx, logic [31:0] v);
        send_cmd(CMD_ALTER, 10'(idx), v, 24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic sample_once(logic [23:0] rg, logic [23:0] rs, logic [23:0] ra);
        send_cmd(CMD_SAMPLE, 10'($urandom), $urandom, rg, rs, ra);
    endtask

    // Quiet the command port and let every outstanding result arrive
    task automatic drain();
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- checker
    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result, index", o_chosen_index, -1);
            end else begin
                want = outcome_q.pop_front();
                if (o_chosen_index !== want.idx)
                    report_mismatch("chosen_index", o_chosen_index, want.idx);
                if (o_chosen_group !== want.grp)
                    report_mismatch("chosen_group", o_chosen_group, want.grp);
                if (o_status !== want.st)
                    report_mismatch("status", o_status, want.st);
            end
        end
    end

    // ---------------------------------------------------------------- tests
    // Nothing filed yet: sampling must report an empty store
    task automatic test_empty_store();
        sample_once(24'hFFFFFF, 24'h0, 24'h0);
        sample_once(24'h0, 24'hFFFFFF, 24'hFFFFFF);
        drain();
    endtask

    // Linear bins of 4.0 from 1.0, sixteen groups
    task automatic test_linear_bins();
        set_regs(1'b1, 32'h10000, 32'h400000, 6'd16, 32'h4000, 32'h40000);
        alter_elem(0, 32'h8000);            // at or below low bound -> group 0
        alter_elem(1023, 32'hFFFF_FFFF);    // far beyond -> saturates to last
        alter_elem(5, 32'h100000);
        alter_elem(5, 32'h110000);          // moves from group 3 to group 4
        alter_elem(7, 32'h10000);           // exactly low bound
        alter_elem(5, 32'h0);               // back to the zero group
        alter_elem(5, 32'h100000);
        sample_once(24'h0, 24'h0, 24'h0);
        sample_once(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        sample_once(24'h800000, 24'h400000, 24'hFFFFFF);
        drain();
        // shrink the group count: stale members stay out of reach,
        // walk runs off the end and lands on an empty group
        write_reg(CFG_NUM_GROUPS, 32'd2);
        i_cfg_valid <= 1'b0;
        sample_once(24'hFFFFFF, 24'h0, 24'h0);
        drain();
    endtask

    // Halving bins, zero high bound and out-of-range group counts
    task automatic test_halving_bins();
        set_regs(1'b0, 32'hFFFF_FFFF, 32'h10000, 6'd8, 32'h0, 32'hFFFF_FFFF);
        alter_elem(20, 32'h10000);
        alter_elem(21, 32'h8000);
        alter_elem(22, 32'h1);              // smallest value, last group
        sample_once(24'h0, 24'h0, 24'h0);
        sample_once(24'hFFFFFF, 24'h123456, 24'h800000);
        drain();
        set_regs(1'b0, 32'h0, 32'h0, 6'd0, 32'h0, 32'h0);
        alter_elem(23, 32'h5);              // zero high bound -> group 0
        sample_once(24'h0, 24'hFFFFFF, 24'h0);
        drain();
        write_reg(CFG_NUM_GROUPS, 32'd63);  // clamped to the maximum
        i_cfg_valid <= 1'b0;
        alter_elem(24, 32'h7);
        sample_once(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        drain();
    endtask

    function automatic logic [31:0] pick_value(logic [31:0] span);
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(span, 1);
        endcase
    endfunction

    // Alters, mostly on a small pool so that lists churn, mixed with attempts in equal share
    task automatic test_random_traffic(int n_items, logic [31:0] span);
        int idx;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 50) begin
                idx = ($urandom_range(9) == 0) ? $urandom_range(N_ELEM - 1)
                                               : $urandom_range(63);
                alter_elem(idx, pick_value(span));
            end else begin
                sample_once(24'($urandom), 24'($urandom), 24'($urandom));
            end
        end
        drain();
    endtask

    task automatic test_random_phases();
        idle_pct = 27;
        set_regs(1'b1, 32'h10000, 32'h400000, 6'd16, 32'h4000, 32'h40000);
        test_random_traffic(150, 32'h480000);
        idle_pct = 78;
        set_regs(1'b0, 32'h0, 32'h800000, 6'd32, 32'h10000, 32'h10000);
        test_random_traffic(150, 32'h900000);
        idle_pct = 0;
        set_regs(1'b1, 32'h8000, 32'h200000, 6'd32, 32'h10000, 32'h10000);
        test_random_traffic(150, 32'h240000);
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cmd           <= CMD_ALTER;
        i_element_index <= '0;
        i_new_value     <= '0;
        i_rand_group    <= '0;
        i_rand_slot     <= '0;
        i_rand_accept   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_BIN_MODE;
        i_cfg_data      <= '0;
        clear_store();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_linear_bins();
        test_halving_bins();
        test_random_phases();

        if (err_cnt == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
